### src/sprite_mask_collision_macros.svh
// Assertion macros shared by the collision block.
`ifndef SPRITE_MASK_COLLISION_MACROS_SVH
`define SPRITE_MASK_COLLISION_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/smc_pkg.sv
package smc_pkg;

  // Mask geometry
  localparam int MAX_SIDE = 64;
  localparam int SIDE_W   = $clog2(MAX_SIDE);
  localparam int CNT_W    = $clog2(MAX_SIDE + 1);
  localparam int ROW_W    = MAX_SIDE;

  // Field widths
  localparam int POS_W = 12;
  localparam int EXT_W = POS_W + 2;
  localparam int CFG_W = 7;
  localparam int PIX_W = 6;
  localparam int ALP_W = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef logic [ROW_W-1:0] row_t;

  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_TEST   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_WIDTH_A  = 2'd0,
    REG_HEIGHT_A = 2'd1,
    REG_WIDTH_B  = 2'd2,
    REG_HEIGHT_B = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_SETUP,
    ST_SCAN
  } state_e;

  // One mask port: a row read and a row write per cycle
  typedef struct packed {
    logic              re;
    logic [SIDE_W-1:0] raddr;
    logic              we;
    logic [SIDE_W-1:0] waddr;
    row_t              wdata;
  } mem_req_t;

  // Clamp a configured size to the mask side
  function automatic logic [CNT_W-1:0] sat_side(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (32'(v) > MAX_SIDE) r = CNT_W'(MAX_SIDE);
    else                   r = CNT_W'(v);
    return r;
  endfunction

endpackage

### src/smc_mask_mem.sv
module smc_mask_mem (
  input  logic            clk_i,
  input  smc_pkg::mem_req_t req_i,
  output smc_pkg::row_t   rdata_o
);
  import smc_pkg::*;

  // one row word per sprite line, bit x = pixel x opaque
  row_t mem [MAX_SIDE];
  row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem[req_i.waddr] <= req_i.wdata;
    if (req_i.re) rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

### src/sprite_mask_collision.sv
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+--------------------------------------
// command  | in        | start_i / busy_o    | kind_i pixel_x_i pixel_y_i alpha_i
//          |           |                     | pos_a_x_i pos_a_y_i pos_b_x_i pos_b_y_i
// result   | out       | done_o (one cycle)  | hit_o
// config   | in        | cfg_we_i            | cfg_idx_i cfg_data_i
//
// A load word is a row read, then a row write-back with one bit changed.
// A test word ends after the overlap setup when the overlap is empty, else it scans
// up to oh rows, oh being the overlap height (at most 64): one row word of each mask per cycle
// through the single read port of each mask memory, stopping at the first hit.
// Reset clears control and sets all sizes to 64; mask contents are undefined.
// done_o pulses for one cycle; the receiver cannot stall, so nothing waits on it.
`include "sprite_mask_collision_macros.svh"

module sprite_mask_collision (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 kind_i,
  input  logic [smc_pkg::PIX_W-1:0]  pixel_x_i,
  input  logic [smc_pkg::PIX_W-1:0]  pixel_y_i,
  input  logic [smc_pkg::ALP_W-1:0]  alpha_i,
  input  logic signed [smc_pkg::POS_W-1:0] pos_a_x_i,
  input  logic signed [smc_pkg::POS_W-1:0] pos_a_y_i,
  input  logic signed [smc_pkg::POS_W-1:0] pos_b_x_i,
  input  logic signed [smc_pkg::POS_W-1:0] pos_b_y_i,
  output logic                       done_o,
  output logic                       hit_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [smc_pkg::CFG_W-1:0]  cfg_data_i
);
  import smc_pkg::*;

  // configuration
  logic [CFG_W-1:0] width_a_q, height_a_q, width_b_q, height_b_q;

  // control
  state_e state_q, state_d;
  logic   done_q, done_d;
  logic   hit_q, hit_d;
  logic   pend_q, pend_d;        // row read in flight
  logic   last_q, last_d;        // in-flight read is the last overlap row
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // load word
  logic              sel_b_q, sel_b_d;
  logic [SIDE_W-1:0] ld_row_q, ld_row_d;
  logic [SIDE_W-1:0] ld_col_q, ld_col_d;
  logic              opq_q, opq_d;

  // test word
  logic signed [POS_W-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [POS_W-1:0] ax_d, ay_d, bx_d, by_d;
  logic [CNT_W-1:0]  oh_q, oh_d;
  logic [SIDE_W-1:0] cax_q, cax_d, cbx_q, cbx_d;
  logic [SIDE_W-1:0] ray_q, ray_d, rby_q, rby_d;
  row_t              colmask_q, colmask_d;

  mem_req_t req_a, req_b;
  row_t     rdata_a, rdata_b;

  // overlap arithmetic
  logic signed [EXT_W-1:0] axe, aye, bxe, bye;
  logic signed [EXT_W-1:0] wae, hae, wbe, hbe;
  logic signed [EXT_W-1:0] ox, oy, rx, ry, ow_s, oh_s;
  logic [CNT_W-1:0]        ow_u;
  logic                    empty;

  logic in_range, row_hit;
  row_t ld_word;
  logic [CNT_W-1:0] cnt_inc;

  smc_mask_mem u_mask_a (.clk_i(clk_i), .req_i(req_a), .rdata_o(rdata_a));
  smc_mask_mem u_mask_b (.clk_i(clk_i), .req_i(req_b), .rdata_o(rdata_b));

  // config register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_a_q  <= CFG_RESET;
      height_a_q <= CFG_RESET;
      width_b_q  <= CFG_RESET;
      height_b_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_WIDTH_A:  width_a_q  <= cfg_data_i;
        REG_HEIGHT_A: height_a_q <= cfg_data_i;
        REG_WIDTH_B:  width_b_q  <= cfg_data_i;
        REG_HEIGHT_B: height_b_q <= cfg_data_i;
      endcase
    end
  end

  // rectangles: [pos, pos + size) on each axis, sizes clamped
  always_comb begin
    axe  = EXT_W'(ax_q);
    aye  = EXT_W'(ay_q);
    bxe  = EXT_W'(bx_q);
    bye  = EXT_W'(by_q);
    wae  = EXT_W'($signed({1'b0, sat_side(width_a_q)}));
    hae  = EXT_W'($signed({1'b0, sat_side(height_a_q)}));
    wbe  = EXT_W'($signed({1'b0, sat_side(width_b_q)}));
    hbe  = EXT_W'($signed({1'b0, sat_side(height_b_q)}));
    ox   = (axe > bxe) ? axe : bxe;
    oy   = (aye > bye) ? aye : bye;
    rx   = ((axe + wae) < (bxe + wbe)) ? (axe + wae) : (bxe + wbe);
    ry   = ((aye + hae) < (bye + hbe)) ? (aye + hae) : (bye + hbe);
    ow_s = rx - ox;
    oh_s = ry - oy;
    // touching edges give zero extent, hence no overlap
    empty = (ow_s <= 0) || (oh_s <= 0);
    ow_u  = ow_s[CNT_W-1:0];
  end

  assign in_range = (32'(pixel_x_i) < MAX_SIDE) && (32'(pixel_y_i) < MAX_SIDE);
  assign cnt_inc  = cnt_q + 1'b1;

  // read data of the selected mask with the loaded bit replaced
  always_comb begin
    ld_word           = sel_b_q ? rdata_b : rdata_a;
    ld_word[ld_col_q] = opq_q;
  end

  // one overlap row of each mask, aligned to the overlap's left column
  assign row_hit = |((rdata_a >> cax_q) & (rdata_b >> cbx_q) & colmask_q);

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    hit_d     = hit_q;
    pend_d    = 1'b0;
    last_d    = last_q;
    cnt_d     = cnt_q;
    sel_b_d   = sel_b_q;
    ld_row_d  = ld_row_q;
    ld_col_d  = ld_col_q;
    opq_d     = opq_q;
    ax_d      = ax_q;
    ay_d      = ay_q;
    bx_d      = bx_q;
    by_d      = by_q;
    oh_d      = oh_q;
    cax_d     = cax_q;
    cbx_d     = cbx_q;
    ray_d     = ray_q;
    rby_d     = rby_q;
    colmask_d = colmask_q;
    req_a     = '0;
    req_b     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (kind_i) inside
            KIND_LOAD_A, KIND_LOAD_B: begin
              if (in_range) begin
                sel_b_d  = (kind_i == KIND_LOAD_B);
                ld_row_d = SIDE_W'(pixel_y_i);
                ld_col_d = SIDE_W'(pixel_x_i);
                opq_d    = |alpha_i;
                req_a.re    = (kind_i == KIND_LOAD_A);
                req_b.re    = (kind_i == KIND_LOAD_B);
                req_a.raddr = SIDE_W'(pixel_y_i);
                req_b.raddr = SIDE_W'(pixel_y_i);
                state_d  = ST_LOAD_WR;
              end
            end
            KIND_TEST: begin
              ax_d    = pos_a_x_i;
              ay_d    = pos_a_y_i;
              bx_d    = pos_b_x_i;
              by_d    = pos_b_y_i;
              state_d = ST_SETUP;
            end
            default: ;  // unused kind: dropped
          endcase
        end
      end

      ST_LOAD_WR: begin
        req_a.we    = !sel_b_q;
        req_b.we    = sel_b_q;
        req_a.waddr = ld_row_q;
        req_b.waddr = ld_row_q;
        req_a.wdata = ld_word;
        req_b.wdata = ld_word;
        state_d     = ST_IDLE;
      end

      ST_SETUP: begin
        if (empty) begin
          done_d  = 1'b1;
          hit_d   = 1'b0;
          state_d = ST_IDLE;
        end else begin
          oh_d      = oh_s[CNT_W-1:0];
          cax_d     = SIDE_W'(ox - axe);
          cbx_d     = SIDE_W'(ox - bxe);
          ray_d     = SIDE_W'(oy - aye);
          rby_d     = SIDE_W'(oy - bye);
          colmask_d = {ROW_W{1'b1}} >> (CNT_W'(MAX_SIDE) - ow_u);
          cnt_d     = '0;
          state_d   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue the next row pair while rows remain
        if (cnt_q < oh_q) begin
          req_a.re    = 1'b1;
          req_b.re    = 1'b1;
          req_a.raddr = ray_q + SIDE_W'(cnt_q);
          req_b.raddr = rby_q + SIDE_W'(cnt_q);
          pend_d      = 1'b1;
          last_d      = (cnt_inc == oh_q);
          cnt_d       = cnt_inc;
        end
        // check the pair read last cycle; stop at first hit or last row
        if (pend_q && (row_hit || last_q)) begin
          done_d  = 1'b1;
          hit_d   = row_hit;
          pend_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      pend_q  <= 1'b0;
      last_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      pend_q  <= pend_d;
      last_q  <= last_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q     <= hit_d;
    sel_b_q   <= sel_b_d;
    ld_row_q  <= ld_row_d;
    ld_col_q  <= ld_col_d;
    opq_q     <= opq_d;
    ax_q      <= ax_d;
    ay_q      <= ay_d;
    bx_q      <= bx_d;
    by_q      <= by_d;
    oh_q      <= oh_d;
    cax_q     <= cax_d;
    cbx_q     <= cbx_d;
    ray_q     <= ray_d;
    rby_q     <= rby_d;
    colmask_q <= colmask_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign hit_o  = hit_q;

  // a result only follows the overlap setup or the row scan
  `SMC_ASSERT_NOW(a_done_src, done_o, $past(state_q == ST_SETUP || state_q == ST_SCAN), "result without a test")
  // a mask write-back always follows a read of that mask
  `SMC_ASSERT_NOW(a_rmw_a, req_a.we, $past(req_a.re), "mask A written without read")
  `SMC_ASSERT_NOW(a_rmw_b, req_b.we, $past(req_b.re), "mask B written without read")
  // no mask is modified while a scan is running
  `SMC_ASSERT_NOW(a_scan_ro, state_q == ST_SCAN, !req_a.we && !req_b.we, "write during scan")
  // the row counter never runs past the overlap height
  `SMC_ASSERT_NEXT(a_cnt_bound, state_q == ST_SCAN, cnt_q <= oh_q, "row counter overrun")

endmodule

### tb/tb_sprite_mask_collision.sv
`timescale 1ns / 100ps

module tb_sprite_mask_collision;
  import smc_pkg::*;

  // Kind code that the block ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Longest test scans the full overlap height; the settle time leaves margin beyond it
  localparam int SETTLE_CYCLES = MAX_SIDE + 8;
  localparam int PHASE_WORDS   = 75;
  localparam int POS_MIN       = -(2 ** (POS_W - 1));
  localparam int POS_MAX       = 2 ** (POS_W - 1) - 1;
  // Side of the corner blocks loaded in each mask before any test
  localparam int FILL_BAND     = 5;
  localparam int PLACE_TRIES   = 40;

  // One command word as presented on the ports
  typedef struct {
    logic [1:0]              kind;
    logic [PIX_W-1:0]        pixel_x;
    logic [PIX_W-1:0]        pixel_y;
    logic [ALP_W-1:0]        alpha;
    logic signed [POS_W-1:0] pos_a_x;
    logic signed [POS_W-1:0] pos_a_y;
    logic signed [POS_W-1:0] pos_b_x;
    logic signed [POS_W-1:0] pos_b_y;
  } cmd_word_t;

  // Shadow of both masks and sizes, and the queue of expected hit flags
  class hit_scoreboard;
    bit               mask_a [MAX_SIDE*MAX_SIDE];
    bit               mask_b [MAX_SIDE*MAX_SIDE];
    bit               wr_a [MAX_SIDE*MAX_SIDE];
    bit               wr_b [MAX_SIDE*MAX_SIDE];
    logic [CFG_W-1:0] size_q [4];
    bit               hit_q [$];
    int unsigned      mismatches;

    function new();
      foreach (size_q[i]) size_q[i] = CFG_RESET;
      mismatches = 0;
    endfunction

    function void set_size(cfg_idx_e idx, logic [CFG_W-1:0] val);
      size_q[idx] = val;
    endfunction

    function int pending();
      return hit_q.size();
    endfunction

    // Sizes above the mask side are clamped to it
    function int side_of(logic [CFG_W-1:0] v);
      return (int'(v) > MAX_SIDE) ? MAX_SIDE : int'(v);
    endfunction

    // Intersect both rectangles, then look for a pixel opaque in both masks
    function bit overlap_hit(int ax, int ay, int bx, int by);
      int x0, y0, x1, y1;
      x0 = (ax > bx) ? ax : bx;
      y0 = (ay > by) ? ay : by;
      x1 = (ax + side_of(size_q[REG_WIDTH_A]) < bx + side_of(size_q[REG_WIDTH_B])) ?
           ax + side_of(size_q[REG_WIDTH_A]) : bx + side_of(size_q[REG_WIDTH_B]);
      y1 = (ay + side_of(size_q[REG_HEIGHT_A]) < by + side_of(size_q[REG_HEIGHT_B])) ?
           ay + side_of(size_q[REG_HEIGHT_A]) : by + side_of(size_q[REG_HEIGHT_B]);
      // empty or edge-only contact: no overlap
      if (x1 <= x0 || y1 <= y0) return 1'b0;
      for (int y = y0; y < y1; y++) begin
        for (int x = x0; x < x1; x++) begin
          if (mask_a[(y - ay) * MAX_SIDE + (x - ax)] &&
              mask_b[(y - by) * MAX_SIDE + (x - bx)]) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // True when every overlap pixel has been loaded in both masks
    function bit all_loaded(int ax, int ay, int bx, int by);
      int x0, y0, x1, y1;
      x0 = (ax > bx) ? ax : bx;
      y0 = (ay > by) ? ay : by;
      x1 = (ax + side_of(size_q[REG_WIDTH_A]) < bx + side_of(size_q[REG_WIDTH_B])) ?
           ax + side_of(size_q[REG_WIDTH_A]) : bx + side_of(size_q[REG_WIDTH_B]);
      y1 = (ay + side_of(size_q[REG_HEIGHT_A]) < by + side_of(size_q[REG_HEIGHT_B])) ?
           ay + side_of(size_q[REG_HEIGHT_A]) : by + side_of(size_q[REG_HEIGHT_B]);
      if (x1 <= x0 || y1 <= y0) return 1'b1;
      for (int y = y0; y < y1; y++) begin
        for (int x = x0; x < x1; x++) begin
          if (!wr_a[(y - ay) * MAX_SIDE + (x - ax)] ||
              !wr_b[(y - by) * MAX_SIDE + (x - bx)]) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void note_word(cmd_word_t w);
      int idx;
      idx = int'(w.pixel_y) * MAX_SIDE + int'(w.pixel_x);
      if (w.kind == KIND_LOAD_A) begin
        mask_a[idx] = (w.alpha != '0);
        wr_a[idx]   = 1'b1;
      end else if (w.kind == KIND_LOAD_B) begin
        mask_b[idx] = (w.alpha != '0);
        wr_b[idx]   = 1'b1;
      end else if (w.kind == KIND_TEST) begin
        hit_q.push_back(overlap_hit(int'(w.pos_a_x), int'(w.pos_a_y),
                                    int'(w.pos_b_x), int'(w.pos_b_y)));
      end
    endfunction

    function void report(string what, logic want, logic got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected hit %b, got %b", $time, what, want, got);
    endfunction

    function void check_hit(logic got);
      bit want;
      if (hit_q.size() == 0) begin
        report("result with no test pending", 1'bx, got);
      end else begin
        want = hit_q.pop_front();
        if (got !== want) report("hit mismatch", want, got);
      end
    endfunction
  endclass

  logic                    clk_i      = 1'b0;
  logic                    rst_ni     = 1'b0;
  logic                    start_i    = 1'b0;
  logic                    busy_o;
  logic [1:0]              kind_i     = '0;
  logic [PIX_W-1:0]        pixel_x_i  = '0;
  logic [PIX_W-1:0]        pixel_y_i  = '0;
  logic [ALP_W-1:0]        alpha_i    = '0;
  logic signed [POS_W-1:0] pos_a_x_i  = '0;
  logic signed [POS_W-1:0] pos_a_y_i  = '0;
  logic signed [POS_W-1:0] pos_b_x_i  = '0;
  logic signed [POS_W-1:0] pos_b_y_i  = '0;
  logic                    done_o;
  logic                    hit_o;
  logic                    cfg_we_i   = 1'b0;
  logic [1:0]              cfg_idx_i  = '0;
  logic [CFG_W-1:0]        cfg_data_i = '0;

  hit_scoreboard sb;
  bit            gaps_on = 1'b1;

  sprite_mask_collision uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .kind_i     (kind_i),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .alpha_i    (alpha_i),
    .pos_a_x_i  (pos_a_x_i),
    .pos_a_y_i  (pos_a_y_i),
    .pos_b_x_i  (pos_b_x_i),
    .pos_b_y_i  (pos_b_y_i),
    .done_o     (done_o),
    .hit_o      (hit_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Result side: done_o is a one-cycle strobe, sampled at the edge ending it
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_hit(hit_o);
  end

  // About one pixel in six opaque, so small overlaps both hit and miss
  function automatic logic [ALP_W-1:0] sparse_alpha();
    return ($urandom_range(5) == 0) ? ALP_W'($urandom_range(255, 1)) : '0;
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_pos(int v);
    if (v > POS_MAX) v = POS_MAX;
    if (v < POS_MIN) v = POS_MIN;
    return POS_W'(v);
  endfunction

  // Offset of B from A on one axis: close, corner contact either way, or a spread
  function automatic int near_offset();
    int unsigned pick;
    pick = $urandom_range(3);
    if (pick == 0) return int'($urandom_range(8)) - 4;
    if (pick == 1) return int'($urandom_range(64, 56));
    if (pick == 2) return -int'($urandom_range(64, 56));
    return int'($urandom_range(140)) - 70;
  endfunction

  // Load word; the position fields carry noise
  function automatic cmd_word_t load_word(logic [1:0] kind, int x, int y,
                                          logic [ALP_W-1:0] alpha);
    cmd_word_t w;
    w.kind    = kind;
    w.pixel_x = PIX_W'(x);
    w.pixel_y = PIX_W'(y);
    w.alpha   = alpha;
    w.pos_a_x = POS_W'($urandom);
    w.pos_a_y = POS_W'($urandom);
    w.pos_b_x = POS_W'($urandom);
    w.pos_b_y = POS_W'($urandom);
    return w;
  endfunction

  // Test word; the pixel fields carry noise
  function automatic cmd_word_t test_word(int ax, int ay, int bx, int by);
    cmd_word_t w;
    w = load_word(KIND_TEST, $urandom, $urandom, ALP_W'($urandom));
    w.pos_a_x = POS_W'(ax);
    w.pos_a_y = POS_W'(ay);
    w.pos_b_x = POS_W'(bx);
    w.pos_b_y = POS_W'(by);
    return w;
  endfunction

  // Random mix: loads, tests (mostly with B placed near A) and a little noise
  function automatic cmd_word_t random_word();
    cmd_word_t   w;
    int unsigned pick;
    pick = $urandom_range(99);
    w = load_word(KIND_LOAD_A, $urandom, $urandom,
                  $urandom_range(1) ? ALP_W'($urandom) : '0);
    if (pick < 5) begin
      w.kind = KIND_UNUSED;
    end else if (pick < 28) begin
      w.kind = KIND_LOAD_A;
    end else if (pick < 50) begin
      w.kind = KIND_LOAD_B;
    end else begin
      w.kind = KIND_TEST;
      // redraw placements whose scan would reach a pixel not loaded yet
      for (int t = 0; t < PLACE_TRIES; t++) begin
        w.pos_a_x = POS_W'($urandom);
        w.pos_a_y = POS_W'($urandom);
        w.pos_b_x = POS_W'($urandom);
        w.pos_b_y = POS_W'($urandom);
        if ($urandom_range(9) < 7) begin
          w.pos_b_x = clamp_pos(int'(w.pos_a_x) + near_offset());
          w.pos_b_y = clamp_pos(int'(w.pos_a_y) + near_offset());
        end
        if (sb.all_loaded(int'(w.pos_a_x), int'(w.pos_a_y),
                          int'(w.pos_b_x), int'(w.pos_b_y))) break;
      end
      // otherwise move B 2048 columns away: no overlap at all
      if (!sb.all_loaded(int'(w.pos_a_x), int'(w.pos_a_y),
                         int'(w.pos_b_x), int'(w.pos_b_y)))
        w.pos_b_x = {~w.pos_a_x[POS_W-1], w.pos_a_x[POS_W-2:0]};
    end
    return w;
  endfunction

  // Offer one word, with random gaps before it; start_i stays high on return
  task automatic send_word(input cmd_word_t w);
    while (gaps_on && $urandom_range(99) < 26) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    kind_i    <= w.kind;
    pixel_x_i <= w.pixel_x;
    pixel_y_i <= w.pixel_y;
    alpha_i   <= w.alpha;
    pos_a_x_i <= w.pos_a_x;
    pos_a_y_i <= w.pos_a_y;
    pos_b_x_i <= w.pos_b_x;
    pos_b_y_i <= w.pos_b_y;
    do @(posedge clk_i); while (busy_o);
    sb.note_word(w);
  endtask

  // Stop issuing, collect every pending hit, then let a trailing load finish
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all four size registers on consecutive edges, block idle
  task automatic set_sizes(input logic [CFG_W-1:0] wa, input logic [CFG_W-1:0] ha,
                           input logic [CFG_W-1:0] wb, input logic [CFG_W-1:0] hb);
    cfg_idx_e         regs [4] = '{REG_WIDTH_A, REG_HEIGHT_A, REG_WIDTH_B, REG_HEIGHT_B};
    logic [CFG_W-1:0] vals [4];
    vals = '{wa, ha, wb, hb};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_size(regs[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load the corner blocks of both masks: mask contents are undefined after
    // reset, so every test is placed to scan loaded pixels only
    for (int y = 0; y < MAX_SIDE; y++) begin
      for (int x = 0; x < MAX_SIDE; x++) begin
        if ((x < FILL_BAND || x >= MAX_SIDE - FILL_BAND) &&
            (y < FILL_BAND || y >= MAX_SIDE - FILL_BAND)) begin
          send_word(load_word(KIND_LOAD_A, x, y, sparse_alpha()));
          send_word(load_word(KIND_LOAD_B, x, y, sparse_alpha()));
        end
      end
    end

    // Directed: corner pixels, alpha extremes, touching edges, far positions
    send_word(load_word(KIND_LOAD_A, 0, 0, 8'hFF));
    send_word(load_word(KIND_LOAD_B, 63, 63, 8'h01));
    send_word(test_word(0, 0, -63, -63));      // single pixel overlap, both opaque
    send_word(load_word(KIND_LOAD_A, 63, 63, 8'h80));
    send_word(load_word(KIND_LOAD_B, 0, 0, 8'hFF));
    send_word(test_word(0, 0, 63, 63));        // A's far corner on B's origin
    send_word(load_word(KIND_LOAD_A, 0, 0, 8'h00));
    send_word(test_word(0, 0, -63, -63));      // same pixel, now transparent
    send_word(load_word(KIND_UNUSED, 5, 5, 8'hFF));
    send_word(test_word(0, 0, 64, 0));         // sharing a vertical edge only
    send_word(test_word(0, 0, 0, 64));         // sharing a horizontal edge only
    send_word(test_word(0, 0, -59, -59));      // corner blocks overlap
    send_word(test_word(-1, -1, -64, 62));
    send_word(test_word(POS_MIN, POS_MIN, POS_MAX, POS_MAX));
    // small sprites at the ends of the position range
    set_sizes(7'd5, 7'd5, 7'd5, 7'd5);
    send_word(test_word(POS_MAX, POS_MAX, POS_MAX, POS_MAX));
    send_word(test_word(POS_MIN, POS_MIN, POS_MIN, POS_MIN));
    send_word(test_word(POS_MAX, POS_MIN, POS_MAX - 3, POS_MIN + 2));
    // oversize A clamped to the mask side
    set_sizes(7'd127, 7'd127, 7'd1, 7'd1);
    send_word(test_word(0, 0, 64, 0));
    send_word(test_word(0, 0, 63, 63));
    // zero width or height gives an empty rectangle
    set_sizes(7'd0, 7'd1, 7'd64, 7'd0);
    send_word(test_word(0, 0, 0, 0));
    set_sizes(7'd64, 7'd0, 7'd0, 7'd64);
    send_word(test_word(10, 10, 10, 10));

    // Random phases, each under its own sizes; phase 2 runs without gaps
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_sizes(7'd64, 7'd64, 7'd64, 7'd64);
        1: set_sizes(7'd1, 7'd1, 7'd1, 7'd1);
        2: set_sizes(CFG_W'($urandom_range(64, 1)), CFG_W'($urandom_range(64, 1)),
                     CFG_W'($urandom_range(64, 1)), CFG_W'($urandom_range(64, 1)));
        3: set_sizes(7'd127, 7'd65, 7'd100, 7'd127);  // oversize, clamped to the mask side
        default: set_sizes(CFG_W'($urandom), CFG_W'($urandom),
                           CFG_W'($urandom), CFG_W'($urandom));
      endcase
      gaps_on = (p != 2);
      repeat (PHASE_WORDS) send_word(random_word());
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
